// ----- rtl/irpfd_pkg.sv -----
// shared types, constants and helpers of the infrared pulse frame decoder
package irpfd_pkg;

  localparam int unsigned CODE_BITS = 32;
  localparam bit          LSB_FIRST = 1'b1;
  localparam logic [15:0] ONE_ON_US = 16'd560;

  localparam int unsigned DurW   = 16;
  localparam int unsigned BitsW  = 6;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned QDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOL          = 4'd0,
    CFG_START_TOTAL  = 4'd1,
    CFG_START_ON     = 4'd2,
    CFG_REPEAT_TOTAL = 4'd3,
    CFG_REPEAT_ON    = 4'd4,
    CFG_ZERO_TOTAL   = 4'd5,
    CFG_ZERO_ON      = 4'd6,
    CFG_ONE_TOTAL    = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    EV_NEW    = 1'b0,
    EV_REPEAT = 1'b1
  } event_kind_e;

  localparam logic [DurW-1:0] RstTol         = 16'd200;
  localparam logic [DurW-1:0] RstStartTotal  = 16'd13500;
  localparam logic [DurW-1:0] RstStartOn     = 16'd9000;
  localparam logic [DurW-1:0] RstRepeatTotal = 16'd11250;
  localparam logic [DurW-1:0] RstRepeatOn    = 16'd9000;
  localparam logic [DurW-1:0] RstZeroTotal   = 16'd1120;
  localparam logic [DurW-1:0] RstZeroOn      = 16'd560;
  localparam logic [DurW-1:0] RstOneTotal    = 16'd2250;

  localparam logic [CodeW-1:0] TopBit  = 32'h8000_0000;
  localparam logic [CodeW-1:0] LowBit  = 32'h0000_0001;
  localparam logic [7:0]       ByteMsk = 8'hff;

  // pulse classification handed from front to back
  typedef struct packed {
    logic is_repeat;
    logic is_start;
    logic is_zero;
    logic is_one;
  } cls_t;

  typedef struct packed {
    logic [$clog2(QDepth+1)-1:0] count;
    logic                        full;
  } q_stat_t;

  typedef struct packed {
    logic code_held;
    logic armed;
  } back_stat_t;

  function automatic logic in_window(input logic [DurW-1:0] measured,
                                     input logic [DurW-1:0] expected,
                                     input logic [DurW-1:0] tol);
    logic [DurW-1:0] lo;
    logic [DurW:0]   hi;
    lo = (expected > tol) ? (expected - tol) : '0;
    hi = {1'b0, expected} + {1'b0, tol};
    return (measured >= lo) && ({1'b0, measured} <= hi);
  endfunction

endpackage

// ----- rtl/irpfd_front.sv -----
// front end: timing registers and pulse pattern classification
module irpfd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irpfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [irpfd_pkg::DurW-1:0]      cfg_wdata_i,
  input  logic [irpfd_pkg::DurW-1:0]      total_i,
  input  logic [irpfd_pkg::DurW-1:0]      on_i,
  output irpfd_pkg::cls_t                 cls_o
);
  import irpfd_pkg::*;

  logic [DurW-1:0] tol_q, start_total_q, start_on_q, repeat_total_q;
  logic [DurW-1:0] repeat_on_q, zero_total_q, zero_on_q, one_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q          <= RstTol;
      start_total_q  <= RstStartTotal;
      start_on_q     <= RstStartOn;
      repeat_total_q <= RstRepeatTotal;
      repeat_on_q    <= RstRepeatOn;
      zero_total_q   <= RstZeroTotal;
      zero_on_q      <= RstZeroOn;
      one_total_q    <= RstOneTotal;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TOL:          tol_q          <= cfg_wdata_i;
        CFG_START_TOTAL:  start_total_q  <= cfg_wdata_i;
        CFG_START_ON:     start_on_q     <= cfg_wdata_i;
        CFG_REPEAT_TOTAL: repeat_total_q <= cfg_wdata_i;
        CFG_REPEAT_ON:    repeat_on_q    <= cfg_wdata_i;
        CFG_ZERO_TOTAL:   zero_total_q   <= cfg_wdata_i;
        CFG_ZERO_ON:      zero_on_q      <= cfg_wdata_i;
        CFG_ONE_TOTAL:    one_total_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cls_o.is_repeat = in_window(total_i, repeat_total_q, tol_q)
                   && in_window(on_i, repeat_on_q, tol_q);
    cls_o.is_start  = in_window(total_i, start_total_q, tol_q)
                   && in_window(on_i, start_on_q, tol_q);
    cls_o.is_zero   = in_window(total_i, zero_total_q, tol_q)
                   && in_window(on_i, zero_on_q, tol_q);
    cls_o.is_one    = in_window(total_i, one_total_q, tol_q)
                   && in_window(on_i, ONE_ON_US, tol_q);
  end

endmodule

// ----- rtl/irpfd_queue.sv -----
// two-entry queue of classified pulses between front and back
module irpfd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  irpfd_pkg::cls_t      push_data_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output irpfd_pkg::cls_t      pop_data_o,
  output irpfd_pkg::q_stat_t   stat_o
);
  import irpfd_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth+1);

  cls_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o    = (cnt_q != CntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign stat_o.count = cnt_q;
  assign stat_o.full  = !ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/irpfd_back.sv -----
// back end: frame state, code assembly and registered result
module irpfd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  irpfd_pkg::cls_t              cls_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_kind_o,
  output logic [irpfd_pkg::CodeW-1:0]  out_code_o,
  output irpfd_pkg::back_stat_t        stat_o
);
  import irpfd_pkg::*;

  logic [CodeW-1:0] shift_q, shift_d, held_q, held_d, code_q, code_d;
  logic [BitsW-1:0] bits_q, bits_d;
  logic             held_v_q, held_v_d;
  logic             ov_q, ov_d, kind_q, kind_d;
  logic             armed, is_bit, bit_val;
  logic [CodeW-1:0] shifted;

  assign pop_o = valid_i && (!ov_q || out_ready_i);

  always_comb begin
    armed   = !cls_i.is_repeat && (bits_q != '0);
    is_bit  = cls_i.is_zero || cls_i.is_one;
    bit_val = cls_i.is_one && !cls_i.is_zero;
    if (LSB_FIRST) begin
      shifted = (shift_q >> 1) | (bit_val ? TopBit : '0);
    end else begin
      shifted = (shift_q << 1) | (bit_val ? LowBit : '0);
    end

    shift_d  = shift_q;
    bits_d   = bits_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    kind_d   = kind_q;
    code_d   = code_q;
    ov_d     = ov_q && !out_ready_i;

    if (pop_o) begin
      if (cls_i.is_repeat && held_v_q) begin
        ov_d   = 1'b1;
        kind_d = EV_REPEAT;
        code_d = held_q;
      end
      if (cls_i.is_start) begin
        bits_d  = BitsW'(CODE_BITS);
        shift_d = '0;
      end else if (armed && is_bit) begin
        shift_d = shifted;
        bits_d  = bits_q - 1'b1;
        if (bits_q == BitsW'(1)) begin
          held_d   = shifted;
          held_v_d = 1'b1;
          ov_d     = 1'b1;
          kind_d   = EV_NEW;
          code_d   = shifted;
        end
      end else begin
        bits_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      bits_q   <= '0;
      held_q   <= '0;
      held_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    code_q <= code_d;
  end

  assign out_valid_o      = ov_q;
  assign out_kind_o       = kind_q;
  assign out_code_o       = code_q;
  assign stat_o.code_held = held_v_q;
  assign stat_o.armed     = (bits_q != '0);

endmodule

// ----- rtl/ir_pulse_frame_decoder.sv -----
// top level of the infrared pulse frame decoder
//
// channel   dir  tdata fields (low bit up)                 tuser
// s_axis    in   pulse_total_us[15:0], pulse_on_us[31:16]  -
// m_axis    out  code_word[31:0], address_byte[39:32],     event_kind
//                command_byte[47:40], check_ok[48]
// cfg       in   index cfg_idx_i, data cfg_wdata_i          -
//
// one pulse per cycle while the queue has space; a result is registered after its pulse
// is accepted (classified into the queue at the accepting edge, then the frame state step)
// the two-entry queue and the output register let either side stall alone
// reset restores the timing registers and clears frame state, no clearing pass
module ir_pulse_frame_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irpfd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [irpfd_pkg::DurW-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // pulse_total_us, pulse_on_us
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [55:0]                      m_axis_tdata,  // code, address, command, check_ok
  output logic                             m_axis_tuser   // event_kind
);
  import irpfd_pkg::*;

  cls_t             front_cls, q_cls;
  q_stat_t          q_stat;
  back_stat_t       b_stat;
  logic             q_valid, q_pop, push;
  logic             out_kind;
  logic [CodeW-1:0] out_code;
  logic [7:0]       addr_b, cmd_b;
  logic             chk_ok;

  assign push = s_axis_tvalid && s_axis_tready;

  irpfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .total_i     (s_axis_tdata[15:0]),
    .on_i        (s_axis_tdata[31:16]),
    .cls_o       (front_cls)
  );

  irpfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cls),
    .ready_o     (s_axis_tready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cls),
    .stat_o      (q_stat)
  );

  irpfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cls_i       (q_cls),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_code_o  (out_code),
    .stat_o      (b_stat)
  );

  assign addr_b = out_code[7:0] & ByteMsk;
  assign cmd_b  = out_code[23:16] & ByteMsk;
  assign chk_ok = (cmd_b == ~out_code[31:24]) && (addr_b == ~out_code[15:8]);

  assign m_axis_tdata = {7'd0, chk_ok, cmd_b, addr_b, out_code};
  assign m_axis_tuser = out_kind;

  // queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= 2'(QDepth))
    else $error("queue count exceeds depth");

  // input stalls only when the queue is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_stat.full)
    else $error("input stalled with queue space");

  // a repeat transaction needs a code delivered before it
  a_rep_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EV_REPEAT) |-> b_stat.code_held)
    else $error("repeat without held code");

  // a new code always disarms reception
  a_new_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid) && m_axis_tuser == EV_NEW) |-> !b_stat.armed ||
    $past(q_cls.is_start))
    else $error("armed after new code");

endmodule
